// File: rtl/json_string_escaper_utf8_check_top_macros.svh
// Assertion macros for the JSON string escaper.
// Included by json_string_escaper_utf8_check_top; no other dependencies.
`ifndef JSON_STRING_ESCAPER_UTF8_CHECK_TOP_MACROS_SVH
`define JSON_STRING_ESCAPER_UTF8_CHECK_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define JSE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("jse: property violated");
`define JSE_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("jse: forbidden condition seen");
`else
`define JSE_ASSERT(label, clk, rst, prop)
`define JSE_NEVER(label, clk, rst, expr)
`endif
`endif

// File: rtl/jse_pkg.sv
// Shared types, character codes and helpers for the JSON string escaper.
// No dependencies; imported by every module of the block.
`default_nettype none
package jse_pkg;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;

  localparam int LEN_W = 4;

  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_ESC,
    TAIL_UNI,
    TAIL_CLOSE
  } tail_t;

  // One queued work packet: everything the back end needs to emit an item.
  typedef struct packed {
    logic             open_q;
    logic [2:0]       n_q;
    logic [1:0]       n_held;
    logic [2:0][7:0]  held;
    tail_t            tail;
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = 8'h41 + {4'd0, v - 4'd10};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/jse_front.sv
// Front end: accepts input items, tracks quote and UTF-8 sequence state,
// and turns each item that gives output into a work packet. Depends on jse_pkg.
`default_nettype none
module jse_front import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_desc
);

  logic       quote_open;
  logic       quote_open_next;
  logic [1:0] bytes_needed;
  logic [1:0] bytes_needed_next;
  logic [1:0] bytes_held;
  logic [1:0] bytes_held_next;
  logic [7:0] held_bytes [3];
  logic       wr_en;
  logic [1:0] wr_idx;
  logic       accept;
  logic       is_cont;
  logic [LEN_W-1:0] tail_len;
  desc_t      d;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (in_byte >= CONT_LO) && (in_byte <= CONT_HI);

  always_comb begin
    d                 = '0;
    d.open_q          = !quote_open;
    d.held[0]         = held_bytes[0];
    d.held[1]         = held_bytes[1];
    d.held[2]         = held_bytes[2];
    d.tail            = TAIL_NONE;
    d.ch              = in_byte;
    quote_open_next   = 1'b1;
    bytes_needed_next = bytes_needed;
    bytes_held_next   = bytes_held;
    wr_en             = 1'b0;
    wr_idx            = 2'd0;
    if (op == OP_END) begin
      d.n_q             = {1'b0, bytes_held};
      d.tail            = TAIL_CLOSE;
      quote_open_next   = 1'b0;
      bytes_needed_next = 2'd0;
      bytes_held_next   = 2'd0;
    end else if (bytes_needed != 2'd0 && is_cont) begin
      if (bytes_held >= bytes_needed) begin
        // sequence complete: release held bytes, then this one
        d.n_held          = bytes_held;
        d.tail            = TAIL_BYTE;
        bytes_needed_next = 2'd0;
        bytes_held_next   = 2'd0;
      end else begin
        wr_en           = 1'b1;
        wr_idx          = bytes_held;
        bytes_held_next = bytes_held + 2'd1;
      end
    end else begin
      // drop any broken sequence as '?', then treat the byte afresh
      d.n_q             = {1'b0, bytes_held};
      bytes_needed_next = 2'd0;
      bytes_held_next   = 2'd0;
      if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
        d.tail = TAIL_ESC;
      end else if (in_byte == CH_LF) begin
        d.tail = TAIL_ESC;
        d.ch   = CH_N;
      end else if (in_byte == CH_CR) begin
        d.tail = TAIL_ESC;
        d.ch   = CH_R;
      end else if (in_byte == CH_TAB) begin
        d.tail = TAIL_ESC;
        d.ch   = CH_T;
      end else if (in_byte < CH_SPACE) begin
        d.tail = TAIL_UNI;
      end else if (in_byte < ASCII_END) begin
        d.tail = TAIL_BYTE;
      end else if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
        wr_en             = 1'b1;
        bytes_held_next   = 2'd1;
        bytes_needed_next = 2'd1;
      end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
        wr_en             = 1'b1;
        bytes_held_next   = 2'd1;
        bytes_needed_next = 2'd2;
      end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
        wr_en             = 1'b1;
        bytes_held_next   = 2'd1;
        bytes_needed_next = 2'd3;
      end else begin
        d.tail = TAIL_BYTE;
        d.ch   = CH_QMARK;
      end
    end
  end

  always_comb begin
    case (d.tail)
      TAIL_BYTE:  tail_len = LEN_W'(1);
      TAIL_ESC:   tail_len = LEN_W'(2);
      TAIL_UNI:   tail_len = LEN_W'(6);
      TAIL_CLOSE: tail_len = LEN_W'(1);
      default:    tail_len = LEN_W'(0);
    endcase
  end

  always_comb begin
    q_desc     = d;
    q_desc.len = LEN_W'(d.open_q) + LEN_W'(d.n_q) + LEN_W'(d.n_held) + tail_len;
  end

  // items that only extend a pending sequence produce nothing
  assign q_push = accept && (q_desc.len != LEN_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_open   <= 1'b0;
      bytes_needed <= 2'd0;
      bytes_held   <= 2'd0;
    end else if (accept) begin
      quote_open   <= quote_open_next;
      bytes_needed <= bytes_needed_next;
      bytes_held   <= bytes_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      case (wr_idx)
        2'd0:    held_bytes[0] <= in_byte;
        2'd1:    held_bytes[1] <= in_byte;
        default: held_bytes[2] <= in_byte;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/jse_queue.sv
// Short packet queue between front and back ends.
// Depends on jse_pkg for the packet type.
`default_nettype none
module jse_queue import jse_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t din,
  input  logic  pop,
  output desc_t dout,
  output logic  full,
  output logic  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == CW'(0));
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

// File: rtl/jse_back.sv
// Back end: expands the head packet into output bytes, one per cycle unless the
// output is stalled, into a registered output stage. Depends on jse_pkg.
`default_nettype none
module jse_back import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  desc_t      q_desc,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       string_done
);

  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] o_end;
  logic [LEN_W-1:0] q_end;
  logic [LEN_W-1:0] h_end;
  logic [LEN_W-1:0] h_off;
  logic [LEN_W-1:0] t_off;
  logic [7:0]       elem;
  logic             elem_done;
  logic             elem_last;
  logic             load;

  assign o_end = LEN_W'(q_desc.open_q);
  assign q_end = o_end + LEN_W'(q_desc.n_q);
  assign h_end = q_end + LEN_W'(q_desc.n_held);
  assign h_off = idx - q_end;
  assign t_off = idx - h_end;

  always_comb begin
    elem      = CH_QUOTE;
    elem_done = 1'b0;
    if (idx < o_end) begin
      elem = CH_QUOTE;
    end else if (idx < q_end) begin
      elem = CH_QMARK;
    end else if (idx < h_end) begin
      case (h_off[1:0])
        2'd0:    elem = q_desc.held[0];
        2'd1:    elem = q_desc.held[1];
        default: elem = q_desc.held[2];
      endcase
    end else begin
      case (q_desc.tail)
        TAIL_BYTE: elem = q_desc.ch;
        TAIL_ESC:  elem = (t_off == LEN_W'(0)) ? CH_BSLASH : q_desc.ch;
        TAIL_UNI: begin
          case (t_off[2:0])
            3'd0:    elem = CH_BSLASH;
            3'd1:    elem = CH_U;
            3'd2:    elem = CH_ZERO;
            3'd3:    elem = CH_ZERO;
            3'd4:    elem = hex_digit(q_desc.ch[7:4]);
            default: elem = hex_digit(q_desc.ch[3:0]);
          endcase
        end
        TAIL_CLOSE: begin
          elem      = CH_QUOTE;
          elem_done = 1'b1;
        end
        default: elem = CH_QMARK;
      endcase
    end
  end

  assign elem_last = (idx == q_desc.len - LEN_W'(1));
  assign load      = !q_empty && (!out_valid || out_ready);
  assign q_pop     = load && elem_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= elem_last ? '0 : idx + LEN_W'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= elem;
      run_last    <= elem_last;
      string_done <= elem_done;
    end
  end

endmodule
`default_nettype wire

// File: rtl/json_string_escaper_utf8_check_top.sv
// JSON string escaper with UTF-8 check, top level.
// The first output byte of an item passes through the packet queue, then the registered output stage.
// One output byte per cycle unless stalled; an item of k bytes holds the back end until all k are out.
// Input is taken every cycle while the packet queue (QUEUE_DEPTH entries) has room.
// Reset clears quote state, the pending UTF-8 sequence, the queue and the output stage.
`default_nettype none
`include "json_string_escaper_utf8_check_top_macros.svh"
module json_string_escaper_utf8_check_top import jse_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       string_done
);

  desc_t push_desc;
  desc_t head_desc;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  jse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_desc),
    .pop   (q_pop),
    .dout  (head_desc),
    .full  (q_full),
    .empty (q_empty)
  );

  jse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_desc      (head_desc),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .run_last    (run_last),
    .string_done (string_done)
  );

  `JSE_NEVER(a_no_overflow, clk, rst, q_push && q_full)
  `JSE_NEVER(a_no_underflow, clk, rst, q_pop && q_empty)
  `JSE_ASSERT(a_close_is_last, clk, rst, out_valid && string_done |-> run_last)

endmodule
`default_nettype wire

// File: dv/tb_json_string_escaper_utf8_check_top.sv
// Testbench for json_string_escaper_utf8_check_top: directed and random strings are sent
// through the escaper, and every output byte is checked against an in-bench prediction.
// Depends on rtl/jse_pkg.sv and the RTL of the block only.
`timescale 1ns / 100ps

module tb_json_string_escaper_utf8_check_top;
  import jse_pkg::*;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 345;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int IDLE_PCT       = 6;

  // Predicts the escaped JSON text byte by byte and checks what comes out.
  class escaped_text_board;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       done;
    } text_byte_t;

    text_byte_t escaped_q[$];
    text_byte_t item_q[$];
    logic       quote_open;
    logic [7:0] held[3];
    logic [1:0] need;
    logic [1:0] nheld;
    int         mismatch_cnt;

    function new();
      quote_open   = 1'b0;
      need         = 2'd0;
      nheld        = 2'd0;
      mismatch_cnt = 0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    function void emit(logic [7:0] c, logic d);
      text_byte_t e;
      e.ch   = c;
      e.last = 1'b0;
      e.done = d;
      item_q.push_back(e);
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n - 4'd10);
    endfunction

    function void flush_held();
      for (int i = 0; i < int'(nheld); i++) emit(CH_QMARK, 1'b0);
      nheld = 2'd0;
      need  = 2'd0;
    endfunction

    // Handle a byte with no UTF-8 sequence pending.
    function void take_fresh(logic [7:0] b);
      if (b == CH_QUOTE || b == CH_BSLASH) begin
        emit(CH_BSLASH, 1'b0);
        emit(b, 1'b0);
      end else if (b == CH_LF) begin
        emit(CH_BSLASH, 1'b0);
        emit(CH_N, 1'b0);
      end else if (b == CH_CR) begin
        emit(CH_BSLASH, 1'b0);
        emit(CH_R, 1'b0);
      end else if (b == CH_TAB) begin
        emit(CH_BSLASH, 1'b0);
        emit(CH_T, 1'b0);
      end else if (b < CH_SPACE) begin
        emit(CH_BSLASH, 1'b0);
        emit(CH_U, 1'b0);
        emit(CH_ZERO, 1'b0);
        emit(CH_ZERO, 1'b0);
        emit(hex_char(b[7:4]), 1'b0);
        emit(hex_char(b[3:0]), 1'b0);
      end else if (b < ASCII_END) begin
        emit(b, 1'b0);
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        held[0] = b; nheld = 2'd1; need = 2'd1;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        held[0] = b; nheld = 2'd1; need = 2'd2;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        held[0] = b; nheld = 2'd1; need = 2'd3;
      end else begin
        emit(CH_QMARK, 1'b0);
      end
    endfunction

    function void note_byte_in(logic o, logic [7:0] b);
      text_byte_t e;
      item_q.delete();
      if (!quote_open) begin
        emit(CH_QUOTE, 1'b0);
        quote_open = 1'b1;
      end
      if (o == OP_END) begin
        flush_held();
        emit(CH_QUOTE, 1'b1);
        quote_open = 1'b0;
      end else if (need != 2'd0) begin
        if (b >= CONT_LO && b <= CONT_HI) begin
          if (nheld >= need) begin
            for (int i = 0; i < int'(nheld); i++) emit(held[i], 1'b0);
            emit(b, 1'b0);
            nheld = 2'd0;
            need  = 2'd0;
          end else begin
            held[nheld] = b;
            nheld = nheld + 2'd1;
          end
        end else begin
          flush_held();
          take_fresh(b);
        end
      end else begin
        take_fresh(b);
      end
      foreach (item_q[i]) begin
        e = item_q[i];
        e.last = (i == item_q.size() - 1);
        escaped_q.push_back(e);
      end
    endfunction

    function void check_char_out(logic [7:0] c, logic l, logic d);
      text_byte_t e;
      if (escaped_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected output: char=%02h run_last=%0b string_done=%0b", c, l, d);
      end else begin
        e = escaped_q.pop_front();
        if (e.ch !== c || e.last !== l || e.done !== d) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp char=%02h last=%0b done=%0b, got char=%02h last=%0b done=%0b",
                     e.ch, e.last, e.done, c, l, d);
        end
      end
    endfunction

    function int pending();
      return escaped_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = OP_DATA;
  logic [7:0] in_byte = 8'h20;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       run_last;
  logic       string_done;

  escaped_text_board board;
  int sent = 0;
  int cycle_cnt = 0;
  bit calm = 1'b0;

  json_string_escaper_utf8_check_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .run_last   (run_last),
    .string_done(string_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("json_string_escaper_utf8_check_top test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_char_out(out_char, run_last, string_done);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic o, input logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte_in(o, b);
    sent++;
    calm = (sent >= 150 && sent < 250);
    @(negedge clk);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(OP_DATA, b);
  endtask

  // Send a UTF-8 lead with random continuations; when not whole, drop some of them.
  task automatic send_utf8_seq(input int cont_cnt, input bit whole);
    int n;
    case (cont_cnt)
      1:       send_data(8'($urandom_range(LEAD2_HI, LEAD2_LO)));
      2:       send_data(8'($urandom_range(LEAD3_HI, LEAD3_LO)));
      default: send_data(8'($urandom_range(LEAD4_HI, LEAD4_LO)));
    endcase
    n = whole ? cont_cnt : $urandom_range(cont_cnt - 1, 0);
    repeat (n) send_data(8'($urandom_range(CONT_HI, CONT_LO)));
  endtask

  initial begin
    int pick;
    int len;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty string, escapes, control bytes, pass-through and bad leads
    send_item(OP_END, 8'hFF);
    send_data(8'h01);
    send_data(8'h1F);
    send_data(CH_QUOTE);
    send_data(CH_BSLASH);
    send_data(CH_LF);
    send_data(CH_CR);
    send_data(CH_TAB);
    send_data(8'h7F);
    send_data(8'hFF);
    send_data(8'h80);
    // well-formed sequences of two, three and four bytes
    send_data(8'hC2); send_data(8'h80);
    send_data(8'hE0); send_data(8'hA0); send_data(8'hBF);
    send_data(8'hF4); send_data(8'h8F); send_data(8'hBF); send_data(8'hBF);
    // broken sequence, then a sequence cut off by end of string
    send_data(8'hE0); send_data(8'h41);
    send_data(8'hF0); send_data(8'h90);
    send_item(OP_END, 8'h01);

    while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      len = $urandom_range(12, 0);
      repeat (len) begin
        pick = $urandom_range(99);
        if (pick < 40)      send_data(8'($urandom_range(8'h7E, CH_SPACE)));
        else if (pick < 50) send_data(8'($urandom_range(8'h1F, 8'h01)));
        else if (pick < 55) send_data($urandom_range(1) ? CH_QUOTE : CH_BSLASH);
        else if (pick < 85) send_utf8_seq($urandom_range(3, 1), 1'b1);
        else if (pick < 95) send_data(8'($urandom_range(255, 1)));
        else                send_utf8_seq($urandom_range(3, 1), 1'b0);
      end
      send_item(OP_END, 8'($urandom_range(255, 1)));
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatch_cnt == 0 && board.pending() == 0) begin
      $display("json_string_escaper_utf8_check_top test passed");
    end else begin
      $display("json_string_escaper_utf8_check_top test failed");
    end
    $finish;
  end

endmodule
